FILE: sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity) + 1;
  localparam int unsigned AddrW    = $clog2(Capacity);

  typedef enum logic [2:0] {
    MODE_HEAD   = 3'd0,
    MODE_TAIL   = 3'd1,
    MODE_AT     = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_SEARCH = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  localparam logic [IdxW-1:0] Nil = IdxW'(Capacity);

  typedef struct packed {
    logic [2:0]  mode;
    logic signed [31:0] item_value;
    logic [6:0]  target_position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] found_position;
    logic [6:0] list_length;
  } rsp_t;

endpackage

FILE: sv/ole_if.sv
// ----------------------------------------------------------------------------
// ole_req_if / ole_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ole_req_if;
  logic          valid;
  logic          ready;
  ole_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ole_rsp_if;
  logic          valid;
  logic          ready;
  ole_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Linked list in a node pool: values and links in two synchronous memories.
// ----------------------------------------------------------------------------
// flow: error and unused modes go from S_DECIDE to S_DONE; inserts pop the free chain
//   (S_FREE_RD, S_ALLOC); tail insert to a non-empty list adds S_LINK_FIX; search, delete
//   and positional insert walk the list (one memory read and one compare per node, up to 64 nodes)
// throughput: one item at a time, the next accepted in the cycle after the result
//   is loaded; a held result stalls S_DONE
// reset: asynchronous; then a clearing pass over every pool entry builds the free chain
module ordered_list_engine_unit (
  input logic       clk_i,
  input logic       rst_ni,
  ole_req_if.sink   req_i,
  ole_rsp_if.source rsp_o
);

  localparam int unsigned IW = ole_pkg::IdxW;
  localparam int unsigned AW = ole_pkg::AddrW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECIDE, S_FREE_RD, S_ALLOC, S_WALK_RD, S_WALK_CHK,
    S_RELEASE, S_LINK_FIX, S_DONE
  } state_e;

  // memories
  logic [31:0]   val_mem [ole_pkg::Capacity];
  logic [IW-1:0] lnk_mem [ole_pkg::Capacity];
  logic [31:0]   val_rd_q;
  logic [IW-1:0] lnk_rd_q;

  state_e            state_q;
  ole_pkg::req_t     req_q;
  ole_pkg::rsp_t     rsp_q;
  logic              rsp_vld_q;
  logic [IW-1:0]     head_q, tail_q, free_q, count_q;
  logic [IW-1:0]     cur_q, prev_q, new_q;
  logic [IW-1:0]     steps_q;
  logic [IW-1:0]     init_q;
  ole_pkg::status_e  st_q;
  logic [6:0]        fpos_q;

  // memory port controls
  logic          lw_en, vw_en, rd_en;
  logic [AW-1:0] lw_addr, vw_addr, rd_addr;
  logic [IW-1:0] lw_data;

  // request decode
  logic pool_full, bad_pos, ins_head, ins_tail, at_prev, val_hit;

  function automatic logic ok_idx(logic [IW-1:0] i);
    return i < IW'(ole_pkg::Capacity);
  endfunction

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  assign pool_full = (count_q >= IW'(ole_pkg::Capacity)) || !ok_idx(free_q);
  assign bad_pos   = (req_q.mode == ole_pkg::MODE_AT) &&
                     (req_q.target_position == '0 ||
                      {1'b0, req_q.target_position} > 8'(count_q) + 8'd1);
  assign ins_head  = (req_q.mode == ole_pkg::MODE_HEAD) ||
                     (req_q.mode == ole_pkg::MODE_AT && req_q.target_position == 7'd1);
  assign ins_tail  = (req_q.mode == ole_pkg::MODE_TAIL) ||
                     (req_q.mode == ole_pkg::MODE_AT &&
                      IW'(req_q.target_position) == count_q + 1'b1);
  assign at_prev   = (steps_q == IW'(req_q.target_position) - 1'b1);
  assign val_hit   = (val_rd_q == req_q.item_value);

  // memory access
  always_ff @(posedge clk_i) begin
    if (lw_en) lnk_mem[lw_addr] <= lw_data;
    if (vw_en) val_mem[vw_addr] <= req_q.item_value;
    if (rd_en) begin
      lnk_rd_q <= lnk_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
    end
  end

  // port drive per state
  always_comb begin
    lw_en = 1'b0; vw_en = 1'b0; rd_en = 1'b0;
    lw_addr = '0; vw_addr = '0; rd_addr = cur_q[AW-1:0]; lw_data = '0;
    unique case (state_q)
      S_INIT: begin
        lw_en = 1'b1; lw_addr = init_q[AW-1:0]; lw_data = init_q + 1'b1;
      end
      S_FREE_RD: begin
        rd_en = 1'b1; rd_addr = free_q[AW-1:0];
      end
      S_WALK_RD: rd_en = 1'b1;
      S_ALLOC: begin
        vw_en = 1'b1; vw_addr = new_q[AW-1:0];
        if (ins_head) begin
          lw_en = 1'b1; lw_addr = new_q[AW-1:0]; lw_data = head_q;
        end else if (ins_tail) begin
          lw_en = 1'b1; lw_addr = new_q[AW-1:0]; lw_data = ole_pkg::Nil;
        end
      end
      S_WALK_CHK: begin
        if (req_q.mode == ole_pkg::MODE_AT) begin
          // new node takes over the link of the node before it
          if (at_prev) begin
            lw_en = 1'b1; lw_addr = new_q[AW-1:0]; lw_data = lnk_rd_q;
          end
        end else if (req_q.mode == ole_pkg::MODE_DELETE && val_hit &&
                     prev_q != ole_pkg::Nil) begin
          // bypass the deleted node
          lw_en = 1'b1; lw_addr = prev_q[AW-1:0]; lw_data = lnk_rd_q;
        end
      end
      S_RELEASE: begin
        lw_en = 1'b1; lw_addr = cur_q[AW-1:0]; lw_data = free_q;
      end
      S_LINK_FIX: begin
        lw_en = 1'b1; lw_addr = prev_q[AW-1:0]; lw_data = new_q;
      end
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      req_q     <= '0;
      rsp_q     <= '0;
      rsp_vld_q <= 1'b0;
      head_q    <= ole_pkg::Nil;
      tail_q    <= ole_pkg::Nil;
      free_q    <= '0;
      count_q   <= '0;
      cur_q     <= ole_pkg::Nil;
      prev_q    <= ole_pkg::Nil;
      new_q     <= ole_pkg::Nil;
      steps_q   <= '0;
      init_q    <= '0;
      st_q      <= ole_pkg::ST_OK;
      fpos_q    <= '0;
    end else begin
      // result register: loaded when free or being taken
      if (state_q == S_DONE && (!rsp_vld_q || rsp_o.ready)) begin
        rsp_q.status         <= st_q;
        rsp_q.found_position <= fpos_q;
        rsp_q.list_length    <= 7'(count_q);
        rsp_vld_q            <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == IW'(ole_pkg::Capacity - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (req_i.valid && req_i.ready) begin
          req_q   <= req_i.payload;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          fpos_q  <= '0;
          cur_q   <= head_q;
          prev_q  <= ole_pkg::Nil;
          steps_q <= '0;
          unique case (req_q.mode) inside
            ole_pkg::MODE_HEAD, ole_pkg::MODE_TAIL, ole_pkg::MODE_AT: begin
              if (pool_full) begin
                st_q    <= ole_pkg::ST_FULL;
                state_q <= S_DONE;
              end else if (bad_pos) begin
                st_q    <= ole_pkg::ST_BADPOS;
                state_q <= S_DONE;
              end else begin
                st_q    <= ole_pkg::ST_OK;
                state_q <= S_FREE_RD;
              end
            end
            ole_pkg::MODE_DELETE: begin
              if (!ok_idx(head_q) || count_q == '0) begin
                st_q    <= ole_pkg::ST_EMPTY;
                state_q <= S_DONE;
              end else begin
                st_q    <= ole_pkg::ST_OK;
                state_q <= S_WALK_RD;
              end
            end
            ole_pkg::MODE_SEARCH: begin
              if (!ok_idx(head_q)) begin
                st_q    <= ole_pkg::ST_NOTFOUND;
                state_q <= S_DONE;
              end else begin
                st_q    <= ole_pkg::ST_OK;
                state_q <= S_WALK_RD;
              end
            end
            default: begin
              st_q    <= ole_pkg::ST_OK;
              state_q <= S_DONE;
            end
          endcase
        end
        S_FREE_RD: begin
          new_q   <= free_q;
          state_q <= S_ALLOC;
        end
        S_ALLOC: begin
          // pop free chain, link new node
          free_q  <= lnk_rd_q;
          count_q <= count_q + 1'b1;
          if (ins_head) begin
            if (!ok_idx(head_q)) tail_q <= new_q;
            head_q  <= new_q;
            state_q <= S_DONE;
          end else if (ins_tail) begin
            if (ok_idx(head_q) && ok_idx(tail_q)) begin
              prev_q  <= tail_q;
              state_q <= S_LINK_FIX;
            end else begin
              head_q  <= new_q;
              state_q <= S_DONE;
            end
            tail_q <= new_q;
          end else begin
            // middle insert: walk to position-1 first
            steps_q <= IW'(1);
            state_q <= S_WALK_RD;
          end
        end
        S_WALK_RD: state_q <= S_WALK_CHK;
        S_WALK_CHK: begin
          if (req_q.mode == ole_pkg::MODE_AT) begin
            if (at_prev) begin
              // cur is prev; splice new after it
              prev_q  <= cur_q;
              if (tail_q == cur_q) tail_q <= new_q;
              state_q <= S_LINK_FIX;
            end else begin
              cur_q   <= lnk_rd_q;
              steps_q <= steps_q + 1'b1;
              state_q <= S_WALK_RD;
            end
          end else if (val_hit) begin
            if (req_q.mode == ole_pkg::MODE_SEARCH) begin
              fpos_q  <= 7'(steps_q + 1'b1);
              state_q <= S_DONE;
            end else begin
              // unlink cur
              if (prev_q == ole_pkg::Nil) begin
                head_q <= lnk_rd_q;
                if (!ok_idx(lnk_rd_q)) tail_q <= ole_pkg::Nil;
              end else if (tail_q == cur_q) begin
                tail_q <= prev_q;
              end
              count_q <= count_q - 1'b1;
              state_q <= S_RELEASE;
            end
          end else if (!ok_idx(lnk_rd_q) || steps_q == IW'(ole_pkg::Capacity - 1)) begin
            st_q    <= ole_pkg::ST_NOTFOUND;
            state_q <= S_DONE;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= lnk_rd_q;
            steps_q <= steps_q + 1'b1;
            state_q <= S_WALK_RD;
          end
        end
        S_RELEASE: begin
          // return deleted node to free chain
          free_q  <= cur_q;
          state_q <= S_DONE;
        end
        S_LINK_FIX: state_q <= S_DONE;
        S_DONE: if (!rsp_vld_q || rsp_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
